/* rtl/sem_pkg.sv */
package sem_pkg;

   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int PIX_W      = CH_W * NUM_CH;
   localparam int GRAD_W     = 11;
   localparam int SUM_W      = 21;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 12'd480;
   localparam logic [IMG_H_W-1:0] ROW_MAX      = 12'd4095;

   localparam logic [SUM_W-1:0] CLAMP_SUM = 21'd65025;
   localparam logic [CH_W-1:0]  MAG_MAX   = 8'd255;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [NUM_CH-1:0][SUM_W-1:0] root_sum_type;

   typedef struct packed {
      logic                         done;
      logic [NUM_CH-1:0][CH_W-1:0]  mag;
   } root_result_type;

endpackage

/* rtl/sobel_edge_magnitude_rgb.sv */
// A pixel that completes a window passes S_READ, S_SQUARE, S_ROOT and S_OUT before its result
// shows on rsp; S_OUT holds while the output register is full. No new item is taken until
// the line buffer read-modify-write and the 8-step shared root unit are done with the last.
// Reset (synchronous): counters, window and frame state clear, size returns to 640 x 480;
// line buffer contents are not cleared.
module sobel_edge_magnitude_rgb #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sem_pkg::PIX_W-1:0]          req_tdata,  // red_in, green_in, blue_in
   input  logic                               req_tuser,  // operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sem_pkg::PIX_W-1:0]          rsp_tdata,  // red_edge, green_edge, blue_edge
   output logic                               rsp_tlast,  // end_of_frame
   input  logic                               csr_we,
   input  logic [sem_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import sem_pkg::*;

   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int MAXW_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = (MAXW_W > IMG_W_W) ? MAXW_W : IMG_W_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SQUARE,
      S_ROOT,
      S_OUT
   } state_type;

   state_type              state_ff, state_in;
   logic [IMG_W_W-1:0]     img_w_ff, img_w_in;
   logic [IMG_H_W-1:0]     img_h_ff, img_h_in;
   logic [ADDR_W-1:0]      in_col_ff, in_col_in;
   logic [IMG_H_W-1:0]     in_row_ff, in_row_in;
   logic [ADDR_W-1:0]      out_col_ff, out_col_in;
   logic [IMG_H_W-1:0]     out_row_ff, out_row_in;
   logic                   done_ff, done_in;
   logic                   op_ff, op_in;
   logic [PIX_W-1:0]       px_ff, px_in;
   logic [PIX_W-1:0]       win_ff [9];
   logic [PIX_W-1:0]       win_in [9];
   logic signed [GRAD_W-1:0] gx_ff [NUM_CH];
   logic signed [GRAD_W-1:0] gx_in [NUM_CH];
   logic signed [GRAD_W-1:0] gy_ff [NUM_CH];
   logic signed [GRAD_W-1:0] gy_in [NUM_CH];
   logic                   eof_ff, eof_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   ram_rd_en;
   logic                   ram_wr_en;
   logic [PIX_W-1:0]       row_rd;
   logic [PIX_W-1:0]       two_rd;

   logic [PIX_W-1:0]       win_shift [9];
   logic [CMP_W-1:0]       eff_w;
   logic [IMG_H_W-1:0]     eff_h;
   logic                   in_last_col;
   logic                   in_last_row;
   logic                   out_last_col;
   logic                   out_last_row;
   logic                   emit;
   logic                   eof_now;
   logic [2:0]             col_black;
   logic [2:0]             row_black;
   logic signed [GRAD_W-1:0] gx_new [NUM_CH];
   logic signed [GRAD_W-1:0] gy_new [NUM_CH];
   logic signed [2*GRAD_W-1:0] gx_sq [NUM_CH];
   logic signed [2*GRAD_W-1:0] gy_sq [NUM_CH];
   root_sum_type           root_sum;
   logic                   root_start;
   root_result_type        root_res;

   sem_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_above (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (in_col_ff),
      .wr_data (px_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (in_col_ff),
      .rd_data (row_rd)
   );

   sem_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_two_rows_above (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (in_col_ff),
      .wr_data (row_rd),
      .rd_en   (ram_rd_en),
      .rd_addr (in_col_ff),
      .rd_data (two_rd)
   );

   sem_root u_root (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .sum_in (root_sum),
      .result (root_res)
   );

   assign req_tready = !reset && (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // window, geometry and gradients for the item in S_READ
   always_comb begin
      logic [CH_W-1:0] v [3][3];
      logic [GRAD_W-1:0] pos;
      logic [GRAD_W-1:0] neg;

      for (int m = 0; m < 6; m++) begin
         win_shift[m] = win_ff[m + 3];
      end
      win_shift[6] = two_rd;
      win_shift[7] = row_rd;
      win_shift[8] = px_ff;

      if (img_w_ff == '0) begin
         eff_w = CMP_W'(1);
      end else if (CMP_W'(img_w_ff) > CMP_W'(MAX_WIDTH)) begin
         eff_w = CMP_W'(MAX_WIDTH);
      end else begin
         eff_w = CMP_W'(img_w_ff);
      end
      eff_h = (img_h_ff == '0) ? IMG_H_W'(1) : img_h_ff;

      in_last_col  = (CMP_W'(in_col_ff) + CMP_W'(1)) >= eff_w;
      in_last_row  = ({1'b0, in_row_ff} + 13'd1) >= {1'b0, eff_h};
      out_last_col = (CMP_W'(out_col_ff) + CMP_W'(1)) >= eff_w;
      out_last_row = ({1'b0, out_row_ff} + 13'd1) >= {1'b0, eff_h};
      emit    = (in_row_ff >= IMG_H_W'(2)) || ((in_row_ff == IMG_H_W'(1)) && (in_col_ff != '0));
      eof_now = out_last_row && out_last_col;

      col_black = {out_last_col, 1'b0, (out_col_ff == '0)};
      row_black = {out_last_row, 1'b0, (out_row_ff == '0)};

      for (int k = 0; k < NUM_CH; k++) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               v[i][j] = (col_black[i] || row_black[j]) ? '0
                         : win_shift[i * 3 + j][PIX_W - 1 - CH_W * k -: CH_W];
            end
         end
         pos = GRAD_W'(v[2][0]) + GRAD_W'({v[2][1], 1'b0}) + GRAD_W'(v[2][2]);
         neg = GRAD_W'(v[0][0]) + GRAD_W'({v[0][1], 1'b0}) + GRAD_W'(v[0][2]);
         gx_new[k] = signed'(pos - neg);
         pos = GRAD_W'(v[0][2]) + GRAD_W'({v[1][2], 1'b0}) + GRAD_W'(v[2][2]);
         neg = GRAD_W'(v[0][0]) + GRAD_W'({v[1][0], 1'b0}) + GRAD_W'(v[2][0]);
         gy_new[k] = signed'(pos - neg);
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         gx_sq[k]    = gx_ff[k] * gx_ff[k];
         gy_sq[k]    = gy_ff[k] * gy_ff[k];
         root_sum[k] = SUM_W'(unsigned'(gx_sq[k]) + unsigned'(gy_sq[k]));
      end
   end

   always_comb begin
      state_in     = state_ff;
      img_w_in     = img_w_ff;
      img_h_in     = img_h_ff;
      in_col_in    = in_col_ff;
      in_row_in    = in_row_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      done_in      = done_ff;
      op_in        = op_ff;
      px_in        = px_ff;
      win_in       = win_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      eof_in       = eof_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      root_start   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            // drop a pixel after the frame and a drain before the frame ends
            if (req_tvalid && req_tready && (req_tuser == done_ff)) begin
               ram_rd_en = 1'b1;
               op_in     = req_tuser;
               px_in     = (req_tuser == OP_DRAIN) ? '0
                           : {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
               state_in  = S_READ;
            end
         end
         S_READ: begin
            ram_wr_en = 1'b1;
            win_in    = win_shift;
            gx_in     = gx_new;
            gy_in     = gy_new;
            eof_in    = eof_now;

            if (in_last_col) begin
               if ((op_ff == OP_PIXEL) && in_last_row) begin
                  done_in = 1'b1;
               end
               in_col_in = '0;
               if (in_row_ff != ROW_MAX) begin
                  in_row_in = in_row_ff + IMG_H_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + ADDR_W'(1);
            end

            if (emit) begin
               state_in = S_SQUARE;
               if (eof_now) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
                  out_row_in = '0;
                  done_in    = 1'b0;
               end else if (out_last_col) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + IMG_H_W'(1);
               end else begin
                  out_col_in = out_col_ff + ADDR_W'(1);
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SQUARE: begin
            root_start = 1'b1;
            state_in   = S_ROOT;
         end
         S_ROOT: begin
            if (root_res.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {root_res.mag[2], root_res.mag[1], root_res.mag[0]};
               rsp_last_in  = eof_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  img_w_in = csr_wdata[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: img_h_in = csr_wdata[IMG_H_W-1:0];
            default: begin
               img_w_in = img_w_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         img_w_ff     <= WIDTH_RESET;
         img_h_ff     <= HEIGHT_RESET;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int m = 0; m < 9; m++) begin
            win_ff[m] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         img_w_ff     <= img_w_in;
         img_h_ff     <= img_h_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      op_ff       <= op_in;
      px_ff       <= px_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      eof_ff      <= eof_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

/* rtl/sem_ram.sv */
module sem_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sem_root.sv */
module sem_root (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  sem_pkg::root_sum_type   sum_in,
   output sem_pkg::root_result_type result
);

   import sem_pkg::*;

   typedef enum logic [1:0] {
      R_IDLE,
      R_STEP,
      R_ROUND
   } root_state_type;

   root_state_type              state_ff, state_in;
   logic [2:0]                  step_ff, step_in;
   logic                        done_ff, done_in;
   logic [NUM_CH-1:0][SUM_W-1:0] sum_ff, sum_in_q;
   logic [NUM_CH-1:0][CH_W-1:0]  n_ff, n_in;
   logic [NUM_CH-1:0][CH_W-1:0]  mag_ff, mag_in;

   logic [CH_W-1:0]    trial;
   logic [2*CH_W-1:0]  trial_sq;
   logic [2*CH_W:0]    upper;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      sum_in_q = sum_ff;
      n_in     = n_ff;
      mag_in   = mag_ff;
      trial    = '0;
      trial_sq = '0;
      upper    = '0;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               sum_in_q = sum_in;
               n_in     = '0;
               step_in  = 3'd7;
               state_in = R_STEP;
            end
         end
         R_STEP: begin
            // one result bit per cycle, most significant first
            for (int k = 0; k < NUM_CH; k++) begin
               trial    = n_ff[k] | (CH_W'(1) << step_ff);
               trial_sq = {{CH_W{1'b0}}, trial} * {{CH_W{1'b0}}, trial};
               if (SUM_W'(trial_sq) <= sum_ff[k]) begin
                  n_in[k] = trial;
               end
            end
            if (step_ff == 3'd0) begin
               state_in = R_ROUND;
            end else begin
               step_in = step_ff - 3'd1;
            end
         end
         R_ROUND: begin
            // clamp from CLAMP_SUM up, else round up when the radicand lies above n*n + n
            for (int k = 0; k < NUM_CH; k++) begin
               upper = ({{(CH_W+1){1'b0}}, n_ff[k]} * {{(CH_W+1){1'b0}}, n_ff[k]})
                       + {{(CH_W+1){1'b0}}, n_ff[k]};
               if (sum_ff[k] >= CLAMP_SUM) begin
                  mag_in[k] = MAG_MAX;
               end else if (sum_ff[k] > SUM_W'(upper)) begin
                  mag_in[k] = n_ff[k] + CH_W'(1);
               end else begin
                  mag_in[k] = n_ff[k];
               end
            end
            done_in  = 1'b1;
            state_in = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
      sum_ff <= sum_in_q;
      n_ff   <= n_in;
      mag_ff <= mag_in;
   end

   assign result.done = done_ff;
   assign result.mag  = mag_ff;

endmodule

/* rtl/sem_checker.sv */
module sem_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared right after an input transfer");

   a_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result loaded while input side was open");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (.*);

/* verif/sobel_edge_magnitude_rgb_tb.sv */
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_tb;
   import sem_pkg::*;

   localparam int          LINE_DEPTH    = 1024;
   localparam int          SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT   = 1500000;

   typedef struct packed {
      logic       frame_end;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } edge_result_t;

   typedef enum int {PIX_RANDOM, PIX_SATURATED, PIX_DIM} pixel_style_t;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [PIX_W-1:0]       req_tdata;   // red_in, green_in, blue_in
   logic                   req_tuser;   // operation
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [PIX_W-1:0]       rsp_tdata;   // red_edge, green_edge, blue_edge
   logic                   rsp_tlast;   // end_of_frame
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // edge predictor state
   logic [PIX_W-1:0]  line_above [LINE_DEPTH] = '{default: '0};
   logic [PIX_W-1:0]  line_two_above [LINE_DEPTH] = '{default: '0};
   logic [PIX_W-1:0]  window_px [9] = '{default: '0};
   int unsigned       in_col = 0;
   int unsigned       in_row = 0;
   int unsigned       out_col = 0;
   int unsigned       out_row = 0;
   bit                frame_fed = 1'b0;
   logic [10:0]       cfg_width = WIDTH_RESET;
   logic [11:0]       cfg_height = HEIGHT_RESET;

   edge_result_t      expected_edges [$];
   int unsigned       fed_count = 0;
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count = 0;
   int unsigned       req_gap_max = 16;
   int unsigned       rsp_gap_max = 16;
   int unsigned       rsp_hold_request = 0;

   sobel_edge_magnitude_rgb #(
      .MAX_WIDTH(LINE_DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [7:0] rounded_root(input int unsigned s);
      int unsigned n;
      int unsigned probe;
      int          b;
      if (s >= CLAMP_SUM) return MAG_MAX;
      n = 0;
      for (b = 7; b >= 0; b--) begin
         probe = n | (1 << b);
         if (probe * probe <= s) n = probe;
      end
      // round up when s lies past the midpoint n*n + n + 1/4
      if (s > n * n + n) n++;
      return n[7:0];
   endfunction

   task automatic sobel_push(input logic op, input logic [PIX_W-1:0] px_in);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int               i;
      int               j;
      int               k;
      int               gx;
      int               gy;
      int               v [3][3];
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] top;
      logic [PIX_W-1:0] mid;
      logic [PIX_W-1:0] nb [3][3];
      logic [7:0]       mag [3];
      bit               emit;
      bit               eof;
      bit               black;
      edge_result_t     res;
      w = (cfg_width == 0) ? 1 : (cfg_width > LINE_DEPTH) ? LINE_DEPTH : int'(cfg_width);
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      if (op == OP_PIXEL) begin
         if (frame_fed) return;
         px = px_in;
      end else begin
         if (!frame_fed) return;
         px = '0;
      end
      fed_count++;

      c = (in_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : in_col;
      top = line_two_above[c];
      mid = line_above[c];
      line_two_above[c] = mid;
      line_above[c] = px;
      for (i = 0; i < 6; i++) window_px[i] = window_px[i + 3];
      window_px[6] = top;
      window_px[7] = mid;
      window_px[8] = px;

      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (in_col + 1 >= w) begin
         if (op == OP_PIXEL && in_row + 1 >= h) frame_fed = 1'b1;
         in_col = 0;
         if (in_row < ROW_MAX) in_row++;
      end else begin
         in_col++;
      end
      if (!emit) return;

      // black out neighbors beyond the frame border
      for (i = 0; i < 3; i++) begin
         for (j = 0; j < 3; j++) begin
            black = (i == 0 && out_col == 0) || (i == 2 && out_col + 1 >= w) ||
                    (j == 0 && out_row == 0) || (j == 2 && out_row + 1 >= h);
            nb[i][j] = black ? '0 : window_px[i * 3 + j];
         end
      end
      for (k = 0; k < 3; k++) begin
         for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) v[i][j] = int'(nb[i][j][8 * k +: 8]);
         end
         gx = (v[2][0] - v[0][0]) + 2 * (v[2][1] - v[0][1]) + (v[2][2] - v[0][2]);
         gy = (v[0][2] + 2 * v[1][2] + v[2][2]) - (v[0][0] + 2 * v[1][0] + v[2][0]);
         mag[k] = rounded_root(gx * gx + gy * gy);
      end

      eof = (out_row + 1 >= h) && (out_col + 1 >= w);
      res.red = mag[0];
      res.green = mag[1];
      res.blue = mag[2];
      res.frame_end = eof;
      expected_edges.push_back(res);

      if (eof) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
         frame_fed = 1'b0;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   function automatic void check_edge_result(input logic [PIX_W-1:0] data,
                                             input logic frame_end);
      edge_result_t want;
      if (expected_edges.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR %0t: result with none expected: data=%h last=%b",
                     $time, data, frame_end);
         return;
      end
      want = expected_edges.pop_front();
      if (data[7:0] !== want.red || data[15:8] !== want.green ||
          data[23:16] !== want.blue || frame_end !== want.frame_end) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR %0t: exp r=%0d g=%0d b=%0d last=%b, got r=%0d g=%0d b=%0d last=%b",
                     $time, want.red, want.green, want.blue, want.frame_end,
                     data[7:0], data[15:8], data[23:16], frame_end);
      end
   endfunction

   // result side: draw a stall per transfer, honor long hold requests
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            check_edge_result(rsp_tdata, rsp_tlast);
            stall_left = $urandom_range(0, rsp_gap_max);
         end
         if (rsp_hold_request != 0) begin
            stall_left = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic op, input logic [PIX_W-1:0] px);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= px;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      sobel_push(op, px);
   endtask

   // drop valid, let every expected result arrive, then cover in-flight work
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [11:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) cfg_width = value[10:0];
      else cfg_height = value;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [11:0] w, input logic [11:0] h);
      wait_for_idle();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   function automatic logic [PIX_W-1:0] make_pixel(input pixel_style_t style);
      logic [PIX_W-1:0] p;
      int               k;
      p = PIX_W'($urandom);
      case (style)
         PIX_SATURATED: begin
            for (k = 0; k < 3; k++) p[8 * k +: 8] = p[8 * k] ? 8'hFF : 8'h00;
         end
         PIX_DIM: begin
            p = p & 24'h070707;
         end
         default: begin
         end
      endcase
      return p;
   endfunction

   // feed pixels until the frame is in, then drain to its last result; noisy adds stray items
   task automatic run_frame(input pixel_style_t style, input bit noisy);
      if (noisy && $urandom_range(0, 1) == 1) send_item(OP_DRAIN, PIX_W'($urandom));
      while (!frame_fed) send_item(OP_PIXEL, make_pixel(style));
      while (frame_fed) begin
         if (noisy && $urandom_range(0, 5) == 0) send_item(OP_PIXEL, PIX_W'($urandom));
         else send_item(OP_DRAIN, PIX_W'($urandom));
      end
   endtask

   task automatic test_directed_corners();
      logic [PIX_W-1:0] corner_px [9] = '{24'hFFFFFF, 24'h000000, 24'hFF00FF,
                                          24'h00FF00, 24'h0180FE, 24'hFFFFFF,
                                          24'h7F7F7F, 24'h000000, 24'hFFFFFF};
      set_geometry(12'd3, 12'd3);
      // drain with no frame in progress is dropped
      send_item(OP_DRAIN, 24'hA5A5A5);
      foreach (corner_px[i]) send_item(OP_PIXEL, corner_px[i]);
      send_item(OP_DRAIN, 24'h000000);
      // pixel while the frame drains is dropped
      send_item(OP_PIXEL, 24'hFFFFFF);
      while (frame_fed) send_item(OP_DRAIN, 24'h000000);
      set_geometry(12'd1, 12'd1);
      send_item(OP_PIXEL, 24'h80FF01);
      while (frame_fed) send_item(OP_DRAIN, 24'hFFFFFF);
   endtask

   task automatic test_size_extremes();
      set_geometry(12'd0, 12'd0);
      run_frame(PIX_SATURATED, 1'b0);
      set_geometry(12'd1, 12'd7);
      run_frame(PIX_RANDOM, 1'b0);
      req_gap_max = 2;
      rsp_gap_max = 2;
      set_geometry(12'd40, 12'd2);
      run_frame(PIX_RANDOM, 1'b0);
      // oversized width acts as the line depth; shrink it before row 0 ends
      set_geometry(12'hFFF, 12'd3);
      repeat (5) send_item(OP_PIXEL, make_pixel(PIX_RANDOM));
      wait_for_idle();
      write_reg(CSR_IMAGE_WIDTH, 12'd3);
      run_frame(PIX_RANDOM, 1'b0);
      // tall frame, one column wide
      set_geometry(12'd1, 12'd60);
      run_frame(PIX_RANDOM, 1'b0);
      req_gap_max = 16;
      rsp_gap_max = 16;
   endtask

   task automatic test_geometry_mid_frame();
      set_geometry(12'd9, 12'd9);
      while (!(in_row == 2 && in_col == 5)) send_item(OP_PIXEL, make_pixel(PIX_RANDOM));
      wait_for_idle();
      write_reg(CSR_IMAGE_WIDTH, 12'd6);
      while (!(in_row == 4 && in_col == 2)) send_item(OP_PIXEL, make_pixel(PIX_RANDOM));
      wait_for_idle();
      write_reg(CSR_IMAGE_HEIGHT, 12'd5);
      run_frame(PIX_RANDOM, 1'b0);
      set_geometry(12'd5, 12'd2);
      while (!(in_row == 1 && in_col == 2)) send_item(OP_PIXEL, make_pixel(PIX_SATURATED));
      wait_for_idle();
      write_reg(CSR_IMAGE_HEIGHT, 12'd4);
      run_frame(PIX_SATURATED, 1'b0);
   endtask

   task automatic test_output_backpressure();
      set_geometry(12'd8, 12'd6);
      rsp_hold_request = 600;
      req_gap_max = 0;
      run_frame(PIX_RANDOM, 1'b0);
      req_gap_max = 16;
      wait_for_idle();
   endtask

   task automatic test_random_frames();
      int unsigned  goal;
      logic [11:0]  w;
      logic [11:0]  h;
      goal = fed_count + 1000;
      while (fed_count < goal) begin
         if ($urandom_range(0, 3) != 0) begin
            w = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 48))
                                            : 12'($urandom_range(1, 10));
            h = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 12))
                                            : 12'($urandom_range(1, 6));
            set_geometry(w, h);
         end
         req_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 16;
         rsp_gap_max = ($urandom_range(0, 4) == 0) ? 0 : 16;
         run_frame(pixel_style_t'($urandom_range(0, 2)), $urandom_range(0, 2) == 0);
      end
      req_gap_max = 16;
      rsp_gap_max = 16;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= OP_PIXEL;
      csr_we <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_size_extremes();
      test_geometry_mid_frame();
      test_output_backpressure();
      test_random_frames();
      wait_for_idle();

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
